FILE: rtl/pts_pkg.sv
// Package: command and status codes and table sizing for the periodic task scheduler
package pts_pkg;
  localparam int MaxEntries = 16;
  localparam int SlotW = $clog2(MaxEntries);
  localparam int CntW = $clog2(MaxEntries + 1);

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_STOP   = 2'd1,
    CMD_SETPER = 2'd2,
    CMD_TICK   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2
  } status_t;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_DISPATCH = 1'b1;
  localparam logic [15:0] DefaultPeriodRst = 16'd10;

  // now + period, saturating at the top of the 32-bit range
  function automatic logic [31:0] sat_add(input logic [31:0] t, input logic [15:0] p);
    logic [32:0] s;
    s = {1'b0, t} + {17'd0, p};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction
endpackage

FILE: rtl/periodic_task_scheduler.sv
// Top level: periodic task table with a slot-serial scan sequencer
//
//  channel | signals                                          | direction
//  in      | in_valid in_ready in_cmd in_entry_id in_period in_now | in
//  out     | out_valid out_ready out_kind out_status out_task_id   | out
//          | out_earliest_due out_table_empty out_last              |
//  cfg     | cfg_we cfg_data                                  | in
//
// One comparator walks the slots, one per cycle, under a small sequencer.
// Start: summary scan, then emit.
// Stop/set period: match scan, apply step, summary scan, emit.
// Tick: summary scan with the rescheduled due times, then one scan plus one
// emit step per dispatch, or a single status emit if nothing is due.
// in_ready returns once the final result has left.
// Reset (synchronous, rst_n low) empties the table; no clearing pass.
// Emit steps wait while out_ready holds a result back; scans run on.
module periodic_task_scheduler
  import pts_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [15:0] in_entry_id,
  input  logic [15:0] in_period,
  input  logic [31:0] in_now,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [1:0]  out_status,
  output logic [15:0] out_task_id,
  output logic [31:0] out_earliest_due,
  output logic        out_table_empty,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_FIND, S_APPLY, S_SUM, S_EMIT, S_TSCAN, S_TDISP
  } state_t;

  state_t state_r;
  logic [MaxEntries-1:0] valid_r, pend_r;
  logic [15:0] slot_id_r [MaxEntries];
  logic [15:0] slot_per_r [MaxEntries];
  logic [31:0] slot_due_r [MaxEntries];

  logic [15:0] defper_r;
  cmd_t        cmd_r;
  logic [15:0] id_r, per_r;
  logic [31:0] now_r;
  logic [SlotW-1:0] idx_r, best_r;
  logic        found_r;
  logic [31:0] bdue_r;
  logic        sum_any_r;
  logic [31:0] sum_due_r;
  logic [1:0]  rst_status_r;
  logic [15:0] rst_id_r;

  logic        ov_r, okind_r, oempty_r, olast_r;
  logic [1:0]  ostat_r;
  logic [15:0] oid_r;
  logic [31:0] odue_r;

  // shared compare unit: does slot idx beat the current best?
  // during a tick's summary scan, due slots count at their rescheduled time
  logic        cand, better, at_end;
  logic [31:0] cmp_due;
  always_comb begin
    unique case (state_r)
      S_FIND:  cand = valid_r[idx_r] && (slot_id_r[idx_r] == id_r);
      S_TSCAN: cand = pend_r[idx_r];
      default: cand = valid_r[idx_r];
    endcase
    cmp_due = (state_r == S_SUM && cmd_r == CMD_TICK && pend_r[idx_r]) ?
              sat_add(now_r, slot_per_r[idx_r]) : slot_due_r[idx_r];
    better = cand && (!found_r || (cmp_due < bdue_r));
    at_end = (idx_r == SlotW'(MaxEntries - 1));
  end

  // lowest free slot (priority encode over valid bits)
  logic [SlotW-1:0] free_idx;
  logic             has_free;
  always_comb begin
    free_idx = '0;
    has_free = 1'b0;
    for (int i = MaxEntries - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = SlotW'(i);
        has_free = 1'b1;
      end
    end
  end

  // final dispatch of a tick: no other slot still pending
  logic [MaxEntries-1:0] pend_left;
  logic                  last_disp;
  always_comb begin
    pend_left = pend_r;
    pend_left[best_r] = 1'b0;
    last_disp = (pend_left == '0);
  end

  // an item is loaded into the output register this cycle
  logic emit_now;
  assign emit_now = (!ov_r || out_ready) &&
                    (state_r == S_EMIT || (state_r == S_TDISP && found_r));

  assign in_ready = (state_r == S_IDLE) && !ov_r;
  assign out_valid = ov_r;
  assign out_kind = okind_r;
  assign out_status = ostat_r;
  assign out_task_id = oid_r;
  assign out_earliest_due = odue_r;
  assign out_table_empty = oempty_r;
  assign out_last = olast_r;

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) defper_r <= DefaultPeriodRst;
    else if (cfg_we) defper_r <= cfg_data;
  end

  // slot payload stores
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid && in_ready && cmd_t'(in_cmd) == CMD_START &&
        has_free) begin
      slot_id_r[free_idx] <= in_entry_id;
      slot_per_r[free_idx] <= defper_r;
      slot_due_r[free_idx] <= sat_add(in_now, defper_r);
    end else if (state_r == S_APPLY && found_r && cmd_r == CMD_SETPER) begin
      slot_per_r[best_r] <= per_r;
      slot_due_r[best_r] <= sat_add(now_r, per_r);
    end else if (state_r == S_TDISP && found_r && (!ov_r || out_ready)) begin
      slot_due_r[best_r] <= sat_add(now_r, slot_per_r[best_r]);
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      pend_r <= '0;
      ov_r <= 1'b0;
      idx_r <= '0;
      found_r <= 1'b0;
    end else begin
      if (ov_r && out_ready && !emit_now) ov_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            cmd_r <= cmd_t'(in_cmd);
            id_r <= in_entry_id;
            per_r <= in_period;
            now_r <= in_now;
            idx_r <= '0;
            found_r <= 1'b0;
            rst_status_r <= ST_OK;
            rst_id_r <= in_entry_id;
            unique case (cmd_t'(in_cmd))
              CMD_START: begin
                if (has_free) valid_r[free_idx] <= 1'b1;
                else rst_status_r <= ST_FULL;
                state_r <= S_SUM;
              end
              CMD_TICK: begin
                for (int i = 0; i < MaxEntries; i++)
                  pend_r[i] <= valid_r[i] && (slot_due_r[i] <= in_now);
                rst_id_r <= '0;
                state_r <= S_SUM;
              end
              default: state_r <= S_FIND;
            endcase
          end
        end
        S_FIND, S_TSCAN: begin
          if (better) begin
            found_r <= 1'b1;
            best_r <= idx_r;
            bdue_r <= cmp_due;
          end
          idx_r <= idx_r + SlotW'(1);
          if (at_end) state_r <= (state_r == S_FIND) ? S_APPLY : S_TDISP;
        end
        S_APPLY: begin
          if (!found_r) rst_status_r <= ST_NOTFOUND;
          else if (cmd_r == CMD_STOP) valid_r[best_r] <= 1'b0;
          found_r <= 1'b0;
          idx_r <= '0;
          state_r <= S_SUM;
        end
        S_TDISP: begin
          if (emit_now) begin
            pend_r[best_r] <= 1'b0;
            ov_r <= 1'b1;
            okind_r <= KIND_DISPATCH;
            ostat_r <= ST_OK;
            oid_r <= slot_id_r[best_r];
            odue_r <= sum_due_r;
            oempty_r <= !sum_any_r;
            olast_r <= last_disp;
            found_r <= 1'b0;
            idx_r <= '0;
            state_r <= last_disp ? S_IDLE : S_TSCAN;
          end
        end
        S_SUM: begin
          if (at_end) begin
            // latch the table summary, then dispatch or report
            sum_any_r <= found_r || better;
            sum_due_r <= better ? cmp_due : (found_r ? bdue_r : '0);
            found_r <= 1'b0;
            idx_r <= '0;
            state_r <= (cmd_r == CMD_TICK && pend_r != '0) ? S_TSCAN : S_EMIT;
          end else begin
            if (better) begin
              found_r <= 1'b1;
              bdue_r <= cmp_due;
            end
            idx_r <= idx_r + SlotW'(1);
          end
        end
        S_EMIT: begin
          if (emit_now) begin
            ov_r <= 1'b1;
            okind_r <= KIND_STATUS;
            ostat_r <= rst_status_r;
            oid_r <= rst_id_r;
            odue_r <= sum_due_r;
            oempty_r <= !sum_any_r;
            olast_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // the output item is held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_task_id))
    else $error("output item dropped while stalled");
  // no new item accepted while the sequencer is busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready)
    else $error("ready while busy");
  // an empty table reports zero earliest due
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last && out_table_empty |-> out_earliest_due == 32'd0)
    else $error("empty table with nonzero due");
`endif
endmodule

FILE: tb/sv/periodic_task_scheduler_test.sv
// Testbench for the periodic task scheduler: queued driver, monitor, table predictor
`timescale 1ns / 1ps

module periodic_task_scheduler_test;
  import pts_pkg::*;

  typedef struct packed {
    cmd_t        cmd;
    logic [15:0] entry_id;
    logic [15:0] period;
    logic [31:0] now;
  } sched_item_t;

  typedef struct packed {
    logic        kind;
    status_t     status;
    logic [15:0] task_id;
    logic [31:0] earliest_due;
    logic        table_empty;
    logic        last;
  } sched_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_cmd;
  logic [15:0] in_entry_id;
  logic [15:0] in_period;
  logic [31:0] in_now;
  logic        out_valid;
  logic        out_ready;
  logic        out_kind;
  logic [1:0]  out_status;
  logic [15:0] out_task_id;
  logic [31:0] out_earliest_due;
  logic        out_table_empty;
  logic        out_last;
  logic        cfg_we;
  logic [15:0] cfg_data;

  // predictor state
  logic        tbl_valid[MaxEntries];
  logic [15:0] tbl_id[MaxEntries];
  logic [15:0] tbl_period[MaxEntries];
  logic [31:0] tbl_due[MaxEntries];
  logic [15:0] start_period;

  sched_item_t   pending_items[$];
  sched_result_t expected_results[$];
  int            mismatch_count;
  int            send_idle_pct;
  int            recv_idle_pct;
  logic [31:0]   clock_now;

  periodic_task_scheduler u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_cmd(in_cmd),
    .in_entry_id(in_entry_id), .in_period(in_period), .in_now(in_now),
    .out_valid(out_valid), .out_ready(out_ready), .out_kind(out_kind),
    .out_status(out_status), .out_task_id(out_task_id),
    .out_earliest_due(out_earliest_due), .out_table_empty(out_table_empty),
    .out_last(out_last), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [31:0] due_after(logic [31:0] t, logic [15:0] p);
    logic [32:0] s;
    s = {1'b0, t} + {17'd0, p};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic void clear_table();
    for (int i = 0; i < MaxEntries; i++) tbl_valid[i] = 1'b0;
  endfunction

  // earliest-due valid slot with this id, -1 if none
  function automatic int earliest_match(logic [15:0] id);
    int best;
    best = -1;
    for (int i = 0; i < MaxEntries; i++)
      if (tbl_valid[i] && tbl_id[i] == id &&
          (best < 0 || tbl_due[i] < tbl_due[best]))
        best = i;
    return best;
  endfunction

  // apply one command to the table and queue the results it produces
  function automatic void schedule_results(sched_item_t it);
    sched_result_t res[$];
    sched_result_t r;
    logic          pend[MaxEntries];
    logic [31:0]   low_due;
    logic          any;
    int            s;
    r = '0;
    case (it.cmd)
      CMD_START: begin
        s = -1;
        for (int i = MaxEntries - 1; i >= 0; i--) if (!tbl_valid[i]) s = i;
        r.task_id = it.entry_id;
        if (s < 0) begin
          r.status = ST_FULL;
        end else begin
          tbl_valid[s] = 1'b1;
          tbl_id[s] = it.entry_id;
          tbl_period[s] = start_period;
          tbl_due[s] = due_after(it.now, start_period);
          r.status = ST_OK;
        end
        res = {res, r};
      end
      CMD_STOP, CMD_SETPER: begin
        s = earliest_match(it.entry_id);
        r.task_id = it.entry_id;
        if (s < 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          r.status = ST_OK;
          if (it.cmd == CMD_STOP) begin
            tbl_valid[s] = 1'b0;
          end else begin
            tbl_period[s] = it.period;
            tbl_due[s] = due_after(it.now, it.period);
          end
        end
        res = {res, r};
      end
      default: begin
        for (int i = 0; i < MaxEntries; i++) pend[i] = tbl_valid[i] && tbl_due[i] <= it.now;
        forever begin
          s = -1;
          for (int i = 0; i < MaxEntries; i++)
            if (pend[i] && (s < 0 || tbl_due[i] < tbl_due[s])) s = i;
          if (s < 0) break;
          pend[s] = 1'b0;
          r = '0;
          r.kind = KIND_DISPATCH;
          r.status = ST_OK;
          r.task_id = tbl_id[s];
          res = {res, r};
          tbl_due[s] = due_after(it.now, tbl_period[s]);
        end
        if (res.size() == 0) begin
          r = '0;
          r.kind = KIND_STATUS;
          r.status = ST_OK;
          res = {res, r};
        end
      end
    endcase
    // table summary after the command
    any = 1'b0;
    low_due = '0;
    for (int i = 0; i < MaxEntries; i++)
      if (tbl_valid[i] && (!any || tbl_due[i] < low_due)) begin
        low_due = tbl_due[i];
        any = 1'b1;
      end
    foreach (res[k]) begin
      res[k].earliest_due = any ? low_due : 32'd0;
      res[k].table_empty = !any;
      res[k].last = (k == res.size() - 1);
      expected_results = {expected_results, res[k]};
    end
  endfunction

  // driver: feeds queued items, predicts on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        schedule_results({cmd_t'(in_cmd), in_entry_id, in_period, in_now});
      if (!in_valid || in_ready) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          sched_item_t it;
          it = pending_items.pop_front();
          in_valid <= 1'b1;
          in_cmd <= it.cmd;
          in_entry_id <= it.entry_id;
          in_period <= it.period;
          in_now <= it.now;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks results in order
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: task_id %0d kind %0d", out_task_id, out_kind);
        end else begin
          sched_result_t e;
          e = expected_results.pop_front();
          if (out_kind !== e.kind || out_status !== e.status || out_task_id !== e.task_id ||
              out_earliest_due !== e.earliest_due || out_table_empty !== e.table_empty ||
              out_last !== e.last) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"mismatch: exp k%0d s%0d id%0d due%0d e%0d l%0d",
                        " got k%0d s%0d id%0d due%0d e%0d l%0d"},
                       e.kind, e.status, e.task_id, e.earliest_due, e.table_empty, e.last,
                       out_kind, out_status, out_task_id, out_earliest_due,
                       out_table_empty, out_last);
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic add_item(cmd_t c, logic [15:0] id, logic [15:0] p, logic [31:0] t);
    sched_item_t it;
    it = {c, id, p, t};
    pending_items = {pending_items, it};
  endtask

  // wait for the block to drain, then write the start period
  task automatic write_start_period(logic [15:0] v);
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(negedge clk);
    repeat (40) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    start_period = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // random phase: mostly live ids from a small pool, advancing time
  task automatic random_phase(int n);
    logic [15:0] id;
    int          pick;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      id = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(7));
      if ($urandom_range(19) == 0) clock_now = $urandom;
      else clock_now = clock_now + $urandom_range(12);
      if (pick < 35) add_item(CMD_START, id, 16'($urandom), clock_now);
      else if (pick < 50) add_item(CMD_STOP, id, 16'($urandom), clock_now);
      else if (pick < 65)
        add_item(CMD_SETPER, id,
                 ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(15)),
                 clock_now);
      else add_item(CMD_TICK, 16'($urandom), 16'($urandom), clock_now);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = CMD_START;
    in_entry_id = '0;
    in_period = '0;
    in_now = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    mismatch_count = 0;
    send_idle_pct = 32;
    recv_idle_pct = 48;
    start_period = DefaultPeriodRst;
    clock_now = 32'd100;
    clear_table();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty-table cases, fill to full, duplicates, ties, saturation
    add_item(CMD_TICK, 16'hFFFF, 16'hFFFF, 32'd0);
    add_item(CMD_STOP, 16'hFFFF, 16'd0, 32'd0);
    add_item(CMD_SETPER, 16'd0, 16'hFFFF, 32'd0);
    for (int i = 0; i < MaxEntries; i++) add_item(CMD_START, 16'(i % 3), 16'd0, 32'd0);
    add_item(CMD_START, 16'hFFFF, 16'd0, 32'd5);
    add_item(CMD_SETPER, 16'd1, 16'd0, 32'd3);
    add_item(CMD_TICK, 16'd0, 16'd0, 32'd10);
    add_item(CMD_STOP, 16'd2, 16'd0, 32'd10);
    add_item(CMD_SETPER, 16'd0, 16'hFFFF, 32'hFFFF_FFF0);
    add_item(CMD_TICK, 16'd0, 16'd0, 32'hFFFF_FFFF);
    add_item(CMD_TICK, 16'd0, 16'd0, 32'hFFFF_FFFF);

    // sender holds off until everything has come back
    write_start_period(16'd1);
    for (int i = 0; i < MaxEntries; i++) add_item(CMD_STOP, 16'(i % 3), 16'd0, 32'd0);
    add_item(CMD_START, 16'hFFFF, 16'd0, 32'hFFFF_FFFF);
    random_phase(25);

    write_start_period(16'hFFFF);
    send_idle_pct = 48;
    recv_idle_pct = 32;
    random_phase(25);

    write_start_period(16'($urandom_range(1, 20)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(25);

    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(negedge clk);
    repeat (100) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0)
      $display("PASS periodic_task_scheduler");
    else
      $display("FAIL periodic_task_scheduler");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL periodic_task_scheduler");
    $finish;
  end

endmodule
